// ----- rtl/matrix3_add_mul_commutator_top_macros.svh -----
// Assertion macros shared by the matrix unit RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef MATRIX3_ADD_MUL_COMMUTATOR_TOP_MACROS_SVH
`define MATRIX3_ADD_MUL_COMMUTATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M3C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define M3C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/m3c_pkg.sv -----
// Package for the matrix unit: sizes, field and operation codes, word types.
// Used by every module of the block but m3c_ram; depends on nothing.
package m3c_pkg;

  localparam int DIM = 3;
  localparam int CELLS = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W = 2;
  localparam int VAL_W = 32;
  localparam int KIND_W = 2;
  localparam int OP_W = 3;
  localparam int STEP_W = $clog2(2 * DIM);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_AB = 3'd2;
  localparam logic [OP_W-1:0] OP_BA = 3'd3;
  localparam logic [OP_W-1:0] OP_COMM = 3'd4;
  localparam logic [OP_W-1:0] OP_ANTI = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } res_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
  } queue_entry_t;

endpackage

// ----- rtl/m3c_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the two matrix stores.
module m3c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/m3c_front.sv -----
// Front end: accepts input words, drops unused kinds and out-of-range loads,
// and turns the rest into queue entries. Depends on m3c_pkg.
module m3c_front (
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  m3c_pkg::cmd_word_t    cmd_data,
  input  logic                  q_full,
  output logic                  push,
  output m3c_pkg::queue_entry_t push_entry
);
  import m3c_pkg::*;

  logic is_load;
  logic in_range;
  logic keep;

  always_comb begin
    is_load = (cmd_data.kind == KIND_LOAD_A) || (cmd_data.kind == KIND_LOAD_B);
    in_range = (int'(cmd_data.row) < DIM) && (int'(cmd_data.col) < DIM);
    keep = (is_load && in_range) || (cmd_data.kind == KIND_COMPUTE);
    cmd_stall = q_full;
    push = cmd_valid && !q_full && keep;
    push_entry.kind = cmd_data.kind;
    push_entry.addr = ADDR_W'(cmd_data.row) * ADDR_W'(DIM) + ADDR_W'(cmd_data.col);
    push_entry.value = cmd_data.value;
  end

endmodule

// ----- rtl/m3c_queue.sv -----
// Short FIFO of classified words between the front end and the back end.
// Depends on m3c_pkg and the assertion macro header.
`include "matrix3_add_mul_commutator_top_macros.svh"

module m3c_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  m3c_pkg::queue_entry_t push_entry,
  output logic                  full,
  output logic                  valid,
  output m3c_pkg::queue_entry_t head,
  input  logic                  pop
);
  import m3c_pkg::*;

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `M3C_ASSERT_NOW(a_no_overflow, push && !pop, !full, "Queue written while full.")
  `M3C_ASSERT_NOW(a_no_underflow, pop, valid, "Queue read while empty.")
  `M3C_ASSERT_NOW(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "Queue count out of range.")

endmodule

// ----- rtl/m3c_back.sv -----
// Back end: writes loads into the two matrix stores and walks the result
// elements through a read, multiply/add and accumulate pipeline into the
// output register. Depends on m3c_pkg, m3c_ram and the assertion macro header.
`include "matrix3_add_mul_commutator_top_macros.svh"

module m3c_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [m3c_pkg::OP_W-1:0] operation,
  input  logic                    q_valid,
  input  m3c_pkg::queue_entry_t   q_head,
  output logic                    q_pop,
  output logic                    res_valid,
  input  logic                    res_stall,
  output m3c_pkg::res_word_t      res_data
);
  import m3c_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  typedef struct packed {
    logic valid;
    logic ew;
    logic sub;
    logic neg;
    logic first;
    logic fin;
  } stage_tag_t;

  logic [1:0]        state;
  logic [IDX_W-1:0]  row_i;
  logic [IDX_W-1:0]  col_j;
  logic [STEP_W-1:0] step;
  stage_tag_t        s1;
  stage_tag_t        s2;
  stage_tag_t        tag;
  logic [VAL_W-1:0]  prod;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  acc_base;
  logic [VAL_W-1:0]  acc_sum;

  logic              ew;
  logic              second_pass;
  logic              pass_ba;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] k;
  logic [ADDR_W-1:0] addr_ij;
  logic [ADDR_W-1:0] addr_ik;
  logic [ADDR_W-1:0] addr_kj;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [VAL_W-1:0]  a_rdata;
  logic [VAL_W-1:0]  b_rdata;
  logic              a_we;
  logic              b_we;
  logic              commit;
  logic              last_elem;

  always_comb begin
    ew = !((operation == OP_AB) || (operation == OP_BA) ||
           (operation == OP_COMM) || (operation == OP_ANTI));
    unique case (operation)
      OP_AB, OP_BA: last_step = STEP_W'(DIM - 1);
      OP_COMM, OP_ANTI: last_step = STEP_W'(2 * DIM - 1);
      default: last_step = '0;
    endcase
    second_pass = (int'(step) >= DIM);
    pass_ba = (operation == OP_BA) || second_pass;
    k = second_pass ? step - STEP_W'(DIM) : step;
    addr_ij = ADDR_W'(row_i) * ADDR_W'(DIM) + ADDR_W'(col_j);
    addr_ik = ADDR_W'(row_i) * ADDR_W'(DIM) + ADDR_W'(k);
    addr_kj = ADDR_W'(k) * ADDR_W'(DIM) + ADDR_W'(col_j);
    if (ew) begin
      a_raddr = addr_ij;
      b_raddr = addr_ij;
    end else if (pass_ba) begin
      a_raddr = addr_kj;
      b_raddr = addr_ik;
    end else begin
      a_raddr = addr_ik;
      b_raddr = addr_kj;
    end
    tag.valid = (state == ST_ISSUE);
    tag.ew = ew;
    tag.sub = (operation == OP_SUB);
    tag.neg = (operation == OP_COMM) && second_pass;
    tag.first = (step == '0);
    tag.fin = (step == last_step);
  end

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign a_we = q_pop && (q_head.kind == KIND_LOAD_A);
  assign b_we = q_pop && (q_head.kind == KIND_LOAD_B);

  m3c_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CELLS)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (q_head.addr),
    .wdata (q_head.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  m3c_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CELLS)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (q_head.addr),
    .wdata (q_head.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign commit = s2.valid && s2.fin;
  assign last_elem = (row_i == IDX_W'(DIM - 1)) && (col_j == IDX_W'(DIM - 1));

  always_comb begin
    acc_base = s2.first ? '0 : acc;
    acc_sum = s2.neg ? acc_base - prod : acc_base + prod;
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      if (s1.ew) begin
        prod <= s1.sub ? a_rdata - b_rdata : a_rdata + b_rdata;
      end else begin
        prod <= a_rdata * b_rdata;
      end
    end
    if (s2.valid) begin
      acc <= acc_sum;
    end
    if (commit) begin
      res_data.out_row <= row_i;
      res_data.out_col <= col_j;
      res_data.out_value <= $signed(acc_sum);
      res_data.last <= last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_i <= '0;
      col_j <= '0;
      step <= '0;
      s1 <= '0;
      s2 <= '0;
      res_valid <= 1'b0;
    end else begin
      s1 <= tag;
      s2 <= s1;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (commit) begin
        res_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && (q_head.kind == KIND_COMPUTE)) begin
            row_i <= '0;
            col_j <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          if (!res_valid || !res_stall) begin
            step <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (step == last_step) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (commit) begin
            if (last_elem) begin
              state <= ST_IDLE;
            end else begin
              if (col_j == IDX_W'(DIM - 1)) begin
                col_j <= '0;
                row_i <= row_i + 1'b1;
              end else begin
                col_j <= col_j + 1'b1;
              end
              state <= ST_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `M3C_ASSERT_NOW(a_commit_into_free, commit, !res_valid, "Result written over a pending word.")
  `M3C_ASSERT_NOW(a_last_ends_compute, res_valid && res_data.last, state == ST_IDLE || state == ST_START, "Last element pending while a compute still runs.")
  `M3C_ASSERT_NEXT(a_issue_feeds_pipe, state == ST_ISSUE, s1.valid, "Issued read did not enter the pipeline.")

endmodule

// ----- rtl/matrix3_add_mul_commutator_top.sv -----
// A load word is accepted one per cycle while the two-entry queue has room; an in-range one is
// stored when the idle back end pops it. The back end walks the nine elements of a compute word one
// at a time (add/subtract element-wise, one product, the commutators as two products), and a stalled
// result holds the next element back. Reads pass the store and product or sum registers before
// the accumulated sum is registered as the result. Synchronous active-high reset clears control
// state and selects add; the matrix stores are not cleared and must be loaded.
module matrix3_add_mul_commutator_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [m3c_pkg::OP_W-1:0] cfg_wdata,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  m3c_pkg::cmd_word_t      cmd_data,
  output logic                    res_valid,
  input  logic                    res_stall,
  output m3c_pkg::res_word_t      res_data
);
  import m3c_pkg::*;

  logic [OP_W-1:0] operation;
  logic            push;
  queue_entry_t    push_entry;
  logic            q_full;
  logic            q_valid;
  queue_entry_t    q_head;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_ADD;
    end else if (cfg_we) begin
      operation <= cfg_wdata;
    end
  end

  m3c_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_data   (cmd_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  m3c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  m3c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .operation (operation),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the 3x3 matrix unit: loads A and B, runs every operation
// code and checks each result word against a built-in model of the matrix arithmetic.
// Depends on m3c_pkg and matrix3_add_mul_commutator_top.
module tb;
  import m3c_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;
  localparam int TARGET_WORDS = 100;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [IDX_W-1:0] IDX_OUT = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fffffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h80000000;
  localparam logic [VAL_W-1:0] VAL_ONES = 32'hffffffff;

  typedef struct {
    logic             set_op;
    logic [OP_W-1:0]  op;
    cmd_word_t        word;
    logic             known;
    logic [VAL_W-1:0] known_value;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [OP_W-1:0] cfg_wdata;
  logic cmd_valid;
  logic cmd_stall;
  cmd_word_t cmd_data;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res_data;

  logic [VAL_W-1:0] a_cells [CELLS];
  logic [VAL_W-1:0] b_cells [CELLS];
  logic [OP_W-1:0] active_op;
  res_word_t expected_elements [$];
  res_word_t oldest_element;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int failures = 0;
  int words_accepted = 0;
  int computes_accepted = 0;
  int elements_checked = 0;
  int op_writes = 0;
  int cycle_count = 0;

  matrix3_add_mul_commutator_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data(cmd_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words outstanding.", cycle_count,
               expected_elements.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] dot_entry(bit a_left, int i, int j);
    logic [VAL_W-1:0] acc;
    int k;
    acc = '0;
    for (k = 0; k < DIM; k++) begin
      if (a_left) begin
        acc += a_cells[i*DIM+k] * b_cells[k*DIM+j];
      end else begin
        acc += b_cells[i*DIM+k] * a_cells[k*DIM+j];
      end
    end
    return acc;
  endfunction

  function automatic logic [VAL_W-1:0] matrix_element(int i, int j);
    case (active_op)
      OP_SUB: begin
        return a_cells[i*DIM+j] - b_cells[i*DIM+j];
      end
      OP_AB: begin
        return dot_entry(1'b1, i, j);
      end
      OP_BA: begin
        return dot_entry(1'b0, i, j);
      end
      OP_COMM: begin
        return dot_entry(1'b1, i, j) - dot_entry(1'b0, i, j);
      end
      OP_ANTI: begin
        return dot_entry(1'b1, i, j) + dot_entry(1'b0, i, j);
      end
      default: begin
        return a_cells[i*DIM+j] + b_cells[i*DIM+j];
      end
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONES;
      4, 5: return $urandom_range(31) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_word_t random_load();
    cmd_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.kind = $urandom_range(1) ? KIND_LOAD_B : KIND_LOAD_A;
    w.row = IDX_W'($urandom_range(DIM - 1));
    w.col = IDX_W'($urandom_range(DIM - 1));
    w.value = random_value();
    if (pick >= 92) begin
      w.kind = KIND_UNUSED;
      w.row = IDX_W'($urandom);
      w.col = IDX_W'($urandom);
    end else if (pick >= 82) begin
      if ($urandom_range(1)) begin
        w.row = IDX_OUT;
      end else begin
        w.col = IDX_OUT;
      end
    end
    return w;
  endfunction

  function automatic plan_row_t plan_row(logic set_op, logic [OP_W-1:0] op,
                                         logic [KIND_W-1:0] kind, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, logic [VAL_W-1:0] value,
                                         logic known, logic [VAL_W-1:0] known_value);
    plan_row_t p;
    p.set_op = set_op;
    p.op = op;
    p.word.kind = kind;
    p.word.row = row;
    p.word.col = col;
    p.word.value = value;
    p.known = known;
    p.known_value = known_value;
    return p;
  endfunction

  task automatic report_failure(string what);
    if (failures < MAX_REPORTS) begin
      $display("%s", what);
    end
    failures++;
  endtask

  // Stores change only on accepted words and the operation only while idle, so the expected
  // matrix is fixed at the moment a compute word is taken.
  task automatic send_word(cmd_word_t word, logic known, logic [VAL_W-1:0] known_value);
    int gap;
    int i;
    int j;
    res_word_t el;
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= word;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    words_accepted++;
    if (word.kind == KIND_LOAD_A || word.kind == KIND_LOAD_B) begin
      if (word.row < DIM && word.col < DIM) begin
        if (word.kind == KIND_LOAD_A) begin
          a_cells[word.row*DIM+word.col] = word.value;
        end else begin
          b_cells[word.row*DIM+word.col] = word.value;
        end
      end
    end else if (word.kind == KIND_COMPUTE) begin
      computes_accepted++;
      for (i = 0; i < DIM; i++) begin
        for (j = 0; j < DIM; j++) begin
          el.out_row = IDX_W'(i);
          el.out_col = IDX_W'(j);
          el.out_value = known ? known_value : matrix_element(i, j);
          el.last = (i == DIM - 1) && (j == DIM - 1);
          expected_elements.push_back(el);
        end
      end
    end
  endtask

  task automatic wait_idle(int settle);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_operation(logic [OP_W-1:0] op);
    wait_idle(QUIET_CYCLES);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= op;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_op = op;
    op_writes++;
  endtask

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      elements_checked++;
      if (expected_elements.size() == 0) begin
        report_failure($sformatf("Unexpected result word: row %0d col %0d value %0d last %0d",
                                 res_data.out_row, res_data.out_col, res_data.out_value,
                                 res_data.last));
      end else begin
        oldest_element = expected_elements.pop_front();
        if (oldest_element.out_row !== res_data.out_row ||
            oldest_element.out_col !== res_data.out_col ||
            oldest_element.out_value !== res_data.out_value ||
            oldest_element.last !== res_data.last) begin
          report_failure($sformatf(
              "Result mismatch: expected row %0d col %0d value %0d last %0d, got %0d %0d %0d %0d",
              oldest_element.out_row, oldest_element.out_col, oldest_element.out_value,
              oldest_element.last, res_data.out_row, res_data.out_col, res_data.out_value,
              res_data.last));
        end
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    cmd_word_t w;
    int i;
    int j;
    int round;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = OP_ADD;
    cmd_valid = 1'b0;
    cmd_data = '0;
    active_op = OP_ADD;
    for (i = 0; i < CELLS; i++) begin
      a_cells[i] = '0;
      b_cells[i] = '0;
    end

    // A holds the largest value everywhere and B the smallest, so A+B and A-B are all ones.
    for (i = 0; i < DIM; i++) begin
      for (j = 0; j < DIM; j++) begin
        plan.push_back(plan_row(1'b0, OP_ADD, KIND_LOAD_A, IDX_W'(i), IDX_W'(j), VAL_MAX,
                                1'b0, '0));
        plan.push_back(plan_row(1'b0, OP_ADD, KIND_LOAD_B, IDX_W'(i), IDX_W'(j), VAL_MIN,
                                1'b0, '0));
      end
    end
    plan.push_back(plan_row(1'b0, OP_ADD, KIND_LOAD_A, IDX_OUT, '0, '0, 1'b0, '0));
    plan.push_back(plan_row(1'b0, OP_ADD, KIND_LOAD_B, IDX_W'(1), IDX_OUT, '0, 1'b0, '0));
    plan.push_back(plan_row(1'b0, OP_ADD, KIND_UNUSED, '0, '0, '0, 1'b0, '0));
    plan.push_back(plan_row(1'b0, OP_ADD, KIND_COMPUTE, '0, '0, '0, 1'b1, VAL_ONES));
    plan.push_back(plan_row(1'b1, OP_SUB, KIND_COMPUTE, IDX_OUT, IDX_OUT, VAL_ONES, 1'b1,
                            VAL_ONES));
    plan.push_back(plan_row(1'b1, OP_SPARE_HI, KIND_COMPUTE, '0, '0, '0, 1'b1, VAL_ONES));
    plan.push_back(plan_row(1'b1, OP_AB, KIND_COMPUTE, '0, '0, '0, 1'b0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].set_op) begin
        set_operation(plan[n].op);
      end
      send_word(plan[n].word, plan[n].known, plan[n].known_value);
    end

    // The first eight rounds walk every operation code, the two spare ones included.
    round = 0;
    while (words_accepted < TARGET_WORDS || round < 8) begin
      case (round % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 60;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 60;
        end
        default: begin
          sender_idle_pct = 34;
          receiver_stall_pct = 34;
        end
      endcase
      set_operation(round < 8 ? OP_W'(round) : OP_W'($urandom_range(7)));
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(3, 10)) begin
          w = random_load();
          send_word(w, 1'b0, '0);
        end
        w.kind = KIND_COMPUTE;
        w.row = IDX_W'($urandom);
        w.col = IDX_W'($urandom);
        w.value = $urandom;
        send_word(w, 1'b0, '0);
      end
      round++;
    end

    wait_idle(DRAIN_CYCLES);
    if (expected_elements.size() != 0) begin
      report_failure($sformatf("%0d result words never arrived.", expected_elements.size()));
    end
    $display("Covered %0d command words (%0d computes) and %0d result words over %0d rounds.",
             words_accepted, computes_accepted, elements_checked, round);
    $display("Operation register written %0d times; %0d failures seen.", op_writes, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
